// ===== sv/fenwick_point_set_range_sum_macros.svh =====
// assertion macros shared by the fenwick tree checker
`ifndef FENWICK_POINT_SET_RANGE_SUM_MACROS_SVH
`define FENWICK_POINT_SET_RANGE_SUM_MACROS_SVH

// same-cycle implication, off while reset is held
`define FWK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define FWK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches the reset itself
`define FWK_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fwk_pkg.sv =====
// shared widths and types of the fenwick tree range sum block
package fwk_pkg;

  localparam int ENTRIES     = 4096;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int IDX_W       = 13;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 64;
  localparam int IN_FIELDS_W = IDX_W + VAL_W + IDX_W + IDX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = SUM_W;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

// ===== sv/fenwick_point_set_range_sum.sv =====
// Point-set / range-sum binary indexed tree over 4096 signed 32-bit values.
// Input channel (in_*): one beat per operation. in_tuser selects the
// operation (0 set, 1 range sum query); in_tdata carries position,
// new_value, range_low and range_high. A valid set gives no result; a query
// or any operation with a bad position or bound gives one result beat.
// Result channel (out_*): out_tdata is the 64-bit two's complement sum,
// out_tuser flags a bad index (sum then zero).
// One operation is in flight at a time. A set reads the old point value, then
// walks the nodes on its update path (at most 13), one tree read-modify-write
// per cycle over the tree memory's read and write ports.
// A query walks the path of range_high and then that of range_low, one tree
// read per node, a node for each set bit of the bound.
// Bad items go straight to the result state.
// After reset both memories are swept to zero, one entry a cycle, with in_tready
// low. A finished result waits in the output register while a new item is
// accepted; the next result holds back until it is taken.
module fenwick_point_set_range_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // position, new_value, range_low, range_high, zero pad
  input  logic [fwk_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // range_sum
  output logic [fwk_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bad_index
  output logic                            out_tuser
);

  localparam int POS_LSB = 0;
  localparam int NV_LSB  = POS_LSB + fwk_pkg::IDX_W;
  localparam int LO_LSB  = NV_LSB + fwk_pkg::VAL_W;
  localparam int HI_LSB  = LO_LSB + fwk_pkg::IDX_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PT   = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_Q    = 3'd4;
  localparam logic [2:0] ST_RES  = 3'd5;

  localparam int UP_W = fwk_pkg::IDX_W + 1;

  function automatic fwk_pkg::idx_t lowbit(input fwk_pkg::idx_t x);
    return x & (~x + fwk_pkg::IDX_W'(1));
  endfunction

  fwk_pkg::sum_t tree_mem [fwk_pkg::ENTRIES];
  fwk_pkg::val_t pt_mem   [fwk_pkg::ENTRIES];

  logic [2:0]     state_r, state_nxt;
  fwk_pkg::addr_t clr_cnt_r, clr_cnt_nxt;
  logic           pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;

  fwk_pkg::idx_t  idx_r, idx_nxt;
  fwk_pkg::idx_t  lo_r, lo_nxt;
  fwk_pkg::val_t  nv_r, nv_nxt;
  logic           phase_hi_r, phase_hi_nxt;
  logic           pend_neg_r, pend_neg_nxt;
  fwk_pkg::sum_t  delta_r, delta_nxt;
  fwk_pkg::sum_t  acc_r, acc_nxt;
  logic           bad_r, bad_nxt;
  fwk_pkg::sum_t  out_sum_r, out_sum_nxt;
  logic           out_bad_r, out_bad_nxt;

  fwk_pkg::sum_t  tree_rdata_r;
  fwk_pkg::val_t  pt_rdata_r;

  logic           tree_re, tree_we, pt_re, pt_we;
  fwk_pkg::addr_t tree_raddr, tree_waddr, pt_raddr, pt_waddr;
  fwk_pkg::sum_t  tree_wdata;
  fwk_pkg::val_t  pt_wdata;

  logic           accept;
  fwk_pkg::idx_t  in_pos, in_lo, in_hi;
  fwk_pkg::val_t  in_nv;
  logic [UP_W-1:0] up_next;

  assign in_pos = in_tdata[POS_LSB +: fwk_pkg::IDX_W];
  assign in_nv  = in_tdata[NV_LSB  +: fwk_pkg::VAL_W];
  assign in_lo  = in_tdata[LO_LSB  +: fwk_pkg::IDX_W];
  assign in_hi  = in_tdata[HI_LSB  +: fwk_pkg::IDX_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_bad_r;

  assign up_next = {1'b0, idx_r} + {1'b0, lowbit(idx_r)};

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    nv_nxt        = nv_r;
    phase_hi_nxt  = phase_hi_r;
    pend_neg_nxt  = pend_neg_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    out_sum_nxt   = out_sum_r;
    out_bad_nxt   = out_bad_r;
    tree_re    = 1'b0;
    tree_raddr = '0;
    tree_we    = 1'b0;
    tree_waddr = '0;
    tree_wdata = '0;
    pt_re      = 1'b0;
    pt_raddr   = '0;
    pt_we      = 1'b0;
    pt_waddr   = '0;
    pt_wdata   = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        tree_we     = 1'b1;
        tree_waddr  = clr_cnt_r;
        pt_we       = 1'b1;
        pt_waddr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + fwk_pkg::ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == fwk_pkg::FUNC_SET) begin
            if (in_pos == '0 || in_pos > fwk_pkg::IDX_W'(fwk_pkg::ENTRIES)) begin
              acc_nxt   = '0;
              bad_nxt   = 1'b1;
              state_nxt = ST_RES;
            end else begin
              pt_re     = 1'b1;
              pt_raddr  = in_pos[fwk_pkg::ADDR_W-1:0];
              idx_nxt   = in_pos;
              nv_nxt    = in_nv;
              state_nxt = ST_PT;
            end
          end else begin
            if (in_hi > fwk_pkg::IDX_W'(fwk_pkg::ENTRIES) || in_lo > in_hi) begin
              acc_nxt   = '0;
              bad_nxt   = 1'b1;
              state_nxt = ST_RES;
            end else begin
              idx_nxt      = in_hi;
              lo_nxt       = in_lo;
              phase_hi_nxt = 1'b1;
              pend_nxt     = 1'b0;
              acc_nxt      = '0;
              bad_nxt      = 1'b0;
              state_nxt    = ST_Q;
            end
          end
        end
      end
      ST_PT: begin
        // difference of sign-extended new and old point values
        delta_nxt  = {{(fwk_pkg::SUM_W-fwk_pkg::VAL_W){nv_r[fwk_pkg::VAL_W-1]}}, nv_r}
                   - {{(fwk_pkg::SUM_W-fwk_pkg::VAL_W){pt_rdata_r[fwk_pkg::VAL_W-1]}},
                      pt_rdata_r};
        pt_we      = 1'b1;
        pt_waddr   = idx_r[fwk_pkg::ADDR_W-1:0];
        pt_wdata   = nv_r;
        tree_re    = 1'b1;
        tree_raddr = idx_r[fwk_pkg::ADDR_W-1:0];
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        // write back this node and fetch the next one up the path
        tree_we    = 1'b1;
        tree_waddr = idx_r[fwk_pkg::ADDR_W-1:0];
        tree_wdata = tree_rdata_r + delta_r;
        if (up_next <= UP_W'(fwk_pkg::ENTRIES)) begin
          idx_nxt    = up_next[fwk_pkg::IDX_W-1:0];
          tree_re    = 1'b1;
          tree_raddr = up_next[fwk_pkg::ADDR_W-1:0];
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_Q: begin
        // upper bound path adds, lower bound path subtracts
        if (pend_r) begin
          acc_nxt = acc_r + (tree_rdata_r ^ {fwk_pkg::SUM_W{pend_neg_r}})
                  + fwk_pkg::SUM_W'(pend_neg_r);
        end
        if (idx_r != '0) begin
          tree_re      = 1'b1;
          tree_raddr   = idx_r[fwk_pkg::ADDR_W-1:0];
          pend_nxt     = 1'b1;
          pend_neg_nxt = !phase_hi_r;
          idx_nxt      = idx_r - lowbit(idx_r);
        end else if (phase_hi_r) begin
          phase_hi_nxt = 1'b0;
          idx_nxt      = lo_r;
          pend_nxt     = 1'b0;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_RES;
          end
        end
      end
      ST_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    lo_r       <= lo_nxt;
    nv_r       <= nv_nxt;
    phase_hi_r <= phase_hi_nxt;
    pend_neg_r <= pend_neg_nxt;
    delta_r    <= delta_nxt;
    acc_r      <= acc_nxt;
    bad_r      <= bad_nxt;
    out_sum_r  <= out_sum_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // tree node sums
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    if (tree_re) begin
      tree_rdata_r <= tree_mem[tree_raddr];
    end
  end

  // point values, position ENTRIES wraps onto entry zero
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_r <= pt_mem[pt_raddr];
    end
  end

endmodule

// ===== sv/fwk_checker.sv =====
// port-level checks for the fenwick tree range sum block, with its bind
`include "fenwick_point_set_range_sum_macros.svh"

module fwk_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fwk_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  `FWK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `FWK_ASSERT_NOW(a_bad_zero, out_tvalid && out_tuser, out_tdata == '0, "bad index result with non-zero sum")
  `FWK_ASSERT_RST(a_rst_quiet, !rst_n, !in_tready && !out_tvalid, "block active straight after reset")
  `FWK_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while one in flight")

endmodule

bind fenwick_point_set_range_sum fwk_checker u_fwk_checker (.*);
